### hdl/lmsc_pkg.sv
// Shared types, constants and the microcode store for the LED matrix shadow controller.
// No dependencies; used by the sequencer, the datapath and the top level.
package lmsc_pkg;

    localparam int MAX_DEVICES = 8;
    localparam int SHADOW_DEPTH = MAX_DEVICES * 8;
    localparam int SHADOW_AW = $clog2(SHADOW_DEPTH);
    localparam int CNT_W = 5;
    localparam int PADDR_W = 3;

    // register index on the config port
    localparam logic REG_DEVICE_COUNT = 1'b0;
    localparam logic [3:0] DEVICE_COUNT_RESET = 4'd8;

    // driver register addresses
    localparam logic [3:0] OPC_DECODE = 4'd9;
    localparam logic [3:0] OPC_INTENSITY = 4'd10;
    localparam logic [3:0] OPC_SCANLIMIT = 4'd11;
    localparam logic [3:0] OPC_SHUTDOWN = 4'd12;
    localparam logic [3:0] OPC_TEST = 4'd15;

    localparam logic [7:0] INTENSITY_LIMIT = 8'd16;
    localparam logic [7:0] SCAN_LIMIT = 8'd8;
    localparam logic [7:0] SCAN_ALL = 8'd7;
    localparam logic [7:0] RESUME_DATA = 8'h01;
    localparam logic [7:0] COL_MSB = 8'h80;
    localparam logic [2:0] LAST_ROW = 3'd7;

    typedef enum logic [2:0] {
        ACT_INIT   = 3'd0,
        ACT_LED    = 3'd1,
        ACT_ROW    = 3'd2,
        ACT_COLUMN = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_SHUT   = 3'd5,
        ACT_INTENS = 3'd6,
        ACT_SCAN   = 3'd7
    } action_t;

    typedef logic [3:0] step_t;

    localparam step_t STEP_IDLE      = 4'd0;
    localparam step_t STEP_INIT_TEST = 4'd1;
    localparam step_t STEP_INIT_SCAN = 4'd2;
    localparam step_t STEP_INIT_DEC  = 4'd3;
    localparam step_t STEP_INIT_CLR  = 4'd4;
    localparam step_t STEP_INIT_SHUT = 4'd5;
    localparam step_t STEP_LED_RD    = 4'd6;
    localparam step_t STEP_LED_WR    = 4'd7;
    localparam step_t STEP_ROW       = 4'd8;
    localparam step_t STEP_COL_RD    = 4'd9;
    localparam step_t STEP_COL_WR    = 4'd10;
    localparam step_t STEP_CLR       = 4'd11;
    localparam step_t STEP_SHUT      = 4'd12;
    localparam step_t STEP_INTENS    = 4'd13;
    localparam step_t STEP_SCAN      = 4'd14;

    typedef enum logic [1:0] {
        DAT_CONST = 2'd0,
        DAT_VALUE = 2'd1,
        DAT_POWER = 2'd2,
        DAT_MERGE = 2'd3
    } dat_sel_t;

    typedef enum logic [1:0] {
        LAST_NONE   = 2'd0,
        LAST_ALWAYS = 2'd1,
        LAST_CNT    = 2'd2
    } last_sel_t;

    typedef enum logic [1:0] {
        FLOW_NEXT     = 2'd0,
        FLOW_END      = 2'd1,
        FLOW_LOOP     = 2'd2,
        FLOW_LOOP_END = 2'd3
    } flow_t;

    // one control word
    typedef struct packed {
        logic      emit;       // frame goes out this step
        logic      opc_row;    // opcode = row + 1, else opc_const
        logic [3:0] opc_const;
        dat_sel_t  dat_sel;
        logic [7:0] dat_const;
        logic      mem_rd;
        logic      mem_wr;
        logic      use_cnt;    // row index from loop counter
        logic      led_src;    // merged bit from value[7-cnt], else led_on
        last_sel_t last_sel;
        logic      cnt_step;
        flow_t     flow;
        step_t     target;
    } uword_t;

    typedef struct packed {
        uword_t     uw;
        logic       fire;
        logic [2:0] cnt;
    } ctrl_t;

    function automatic uword_t ucode_rom(step_t s);
        uword_t uw;
        uw = '0;
        uw.flow = FLOW_END;
        case (s)
            STEP_INIT_TEST: begin
                uw.emit = 1'b1; uw.opc_const = OPC_TEST; uw.flow = FLOW_NEXT;
            end
            STEP_INIT_SCAN: begin
                uw.emit = 1'b1; uw.opc_const = OPC_SCANLIMIT;
                uw.dat_const = SCAN_ALL; uw.flow = FLOW_NEXT;
            end
            STEP_INIT_DEC: begin
                uw.emit = 1'b1; uw.opc_const = OPC_DECODE; uw.flow = FLOW_NEXT;
            end
            STEP_INIT_CLR: begin
                uw.emit = 1'b1; uw.opc_row = 1'b1; uw.use_cnt = 1'b1; uw.mem_wr = 1'b1;
                uw.cnt_step = 1'b1; uw.flow = FLOW_LOOP; uw.target = STEP_INIT_CLR;
            end
            STEP_INIT_SHUT: begin
                uw.emit = 1'b1; uw.opc_const = OPC_SHUTDOWN; uw.last_sel = LAST_ALWAYS;
            end
            STEP_LED_RD: begin
                uw.mem_rd = 1'b1; uw.flow = FLOW_NEXT;
            end
            STEP_LED_WR: begin
                uw.emit = 1'b1; uw.opc_row = 1'b1; uw.dat_sel = DAT_MERGE;
                uw.mem_wr = 1'b1; uw.last_sel = LAST_ALWAYS;
            end
            STEP_ROW: begin
                uw.emit = 1'b1; uw.opc_row = 1'b1; uw.dat_sel = DAT_VALUE;
                uw.mem_wr = 1'b1; uw.last_sel = LAST_ALWAYS;
            end
            STEP_COL_RD: begin
                uw.mem_rd = 1'b1; uw.use_cnt = 1'b1; uw.flow = FLOW_NEXT;
            end
            STEP_COL_WR: begin
                uw.emit = 1'b1; uw.opc_row = 1'b1; uw.dat_sel = DAT_MERGE;
                uw.mem_wr = 1'b1; uw.use_cnt = 1'b1; uw.led_src = 1'b1;
                uw.last_sel = LAST_CNT; uw.cnt_step = 1'b1;
                uw.flow = FLOW_LOOP_END; uw.target = STEP_COL_RD;
            end
            STEP_CLR: begin
                uw.emit = 1'b1; uw.opc_row = 1'b1; uw.use_cnt = 1'b1; uw.mem_wr = 1'b1;
                uw.last_sel = LAST_CNT; uw.cnt_step = 1'b1;
                uw.flow = FLOW_LOOP_END; uw.target = STEP_CLR;
            end
            STEP_SHUT: begin
                uw.emit = 1'b1; uw.opc_const = OPC_SHUTDOWN; uw.dat_sel = DAT_POWER;
                uw.last_sel = LAST_ALWAYS;
            end
            STEP_INTENS: begin
                uw.emit = 1'b1; uw.opc_const = OPC_INTENSITY; uw.dat_sel = DAT_VALUE;
                uw.last_sel = LAST_ALWAYS;
            end
            STEP_SCAN: begin
                uw.emit = 1'b1; uw.opc_const = OPC_SCANLIMIT; uw.dat_sel = DAT_VALUE;
                uw.last_sel = LAST_ALWAYS;
            end
            default: begin
                uw.flow = FLOW_END;
            end
        endcase
        return uw;
    endfunction

    function automatic step_t entry_step(action_t a);
        step_t s;
        s = STEP_IDLE;
        case (a)
            ACT_INIT:   s = STEP_INIT_TEST;
            ACT_LED:    s = STEP_LED_RD;
            ACT_ROW:    s = STEP_ROW;
            ACT_COLUMN: s = STEP_COL_RD;
            ACT_CLEAR:  s = STEP_CLR;
            ACT_SHUT:   s = STEP_SHUT;
            ACT_INTENS: s = STEP_INTENS;
            ACT_SCAN:   s = STEP_SCAN;
            default:    s = STEP_IDLE;
        endcase
        return s;
    endfunction

endpackage

### hdl/lmsc_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module lmsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lmsc_sequencer.sv
// Microcode sequencer: step counter, row loop counter, command dispatch and range checks.
// Depends on lmsc_pkg (control word store, step codes).
module lmsc_sequencer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  lmsc_pkg::action_t     action,
    input  logic [2:0]            device,
    input  logic [7:0]            value,
    input  logic [3:0]            device_count,
    input  logic                  out_free,
    output logic                  busy,
    output lmsc_pkg::ctrl_t       ctrl
);
    import lmsc_pkg::*;

    step_t      pc_reg, pc_next;
    logic [2:0] cnt_reg, cnt_next;
    uword_t     uw;
    logic       fire;
    logic       cnt_last;
    logic [CNT_W-1:0] active;
    logic       cmd_ok;

    // zero or above the maximum means all devices
    always_comb
    begin
        if (device_count == 4'd0 || {1'b0, device_count} > CNT_W'(MAX_DEVICES))
        begin
            active = CNT_W'(MAX_DEVICES);
        end
        else
        begin
            active = CNT_W'(device_count);
        end
    end

    always_comb
    begin
        cmd_ok = CNT_W'(device) < active;
        if (action == ACT_INTENS && value >= INTENSITY_LIMIT)
        begin
            cmd_ok = 1'b0;
        end
        if (action == ACT_SCAN && value >= SCAN_LIMIT)
        begin
            cmd_ok = 1'b0;
        end
    end

    assign uw = ucode_rom(pc_reg);
    assign busy = pc_reg != STEP_IDLE;
    assign fire = busy && (!uw.emit || out_free);
    assign cnt_last = cnt_reg == LAST_ROW;

    always_comb
    begin
        pc_next = pc_reg;
        cnt_next = cnt_reg;
        if (!busy)
        begin
            cnt_next = 3'd0;
            if (start && cmd_ok)
            begin
                pc_next = entry_step(action);
            end
        end
        else if (fire)
        begin
            if (uw.cnt_step)
            begin
                cnt_next = cnt_reg + 3'd1;
            end
            case (uw.flow)
                FLOW_NEXT:     pc_next = pc_reg + step_t'(1);
                FLOW_END:      pc_next = STEP_IDLE;
                FLOW_LOOP:     pc_next = cnt_last ? pc_reg + step_t'(1) : uw.target;
                FLOW_LOOP_END: pc_next = cnt_last ? STEP_IDLE : uw.target;
                default:       pc_next = STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
            cnt_reg <= 3'd0;
        end
        else
        begin
            pc_reg <= pc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign ctrl.uw = uw;
    assign ctrl.fire = fire;
    assign ctrl.cnt = cnt_reg;

endmodule

### hdl/lmsc_datapath.sv
// Datapath: command registers, row shadow RAM with valid bits, byte merge, frame register.
// Depends on lmsc_pkg and lmsc_ram.
module lmsc_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        device,
    input  logic [2:0]        row,
    input  logic [2:0]        column,
    input  logic [7:0]        value,
    input  logic              led_on,
    input  logic              power_down,
    input  lmsc_pkg::ctrl_t   ctrl,
    output logic              out_free,
    input  logic              out_stall,
    output logic              out_valid,
    output logic [2:0]        device_res,
    output logic [3:0]        opcode,
    output logic [7:0]        data,
    output logic              last
);
    import lmsc_pkg::*;

    logic [2:0] dev_reg, row_reg, col_reg;
    logic [7:0] value_reg;
    logic       led_on_reg, pwr_reg;

    logic [2:0] row_sel;
    logic [SHADOW_AW-1:0] addr;
    logic [7:0] rdata, old_byte, mask, merged, dat;
    logic       bit_val;
    logic [3:0] opc;
    logic       last_bit;
    logic       we, re, load;

    logic [SHADOW_DEPTH-1:0] valid_reg, valid_next;
    logic       rd_valid_reg;

    logic       out_valid_reg, out_valid_next;
    logic [2:0] dev_out_reg;
    logic [3:0] opc_out_reg;
    logic [7:0] data_out_reg;
    logic       last_out_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dev_reg <= device;
            row_reg <= row;
            col_reg <= column;
            value_reg <= value;
            led_on_reg <= led_on;
            pwr_reg <= power_down;
        end
    end

    assign row_sel = ctrl.uw.use_cnt ? ctrl.cnt : row_reg;
    assign addr = SHADOW_AW'({dev_reg, row_sel});
    assign we = ctrl.fire && ctrl.uw.mem_wr;
    assign re = ctrl.fire && ctrl.uw.mem_rd;

    lmsc_ram #(
        .WIDTH(8),
        .DEPTH(SHADOW_DEPTH)
    ) u_shadow (
        .clk  (clk),
        .we   (we),
        .waddr(addr),
        .wdata(dat),
        .re   (re),
        .raddr(addr),
        .rdata(rdata)
    );

    // entries never written read as a cleared row
    always_comb
    begin
        valid_next = valid_reg;
        if (we)
        begin
            valid_next[addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (re)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    assign old_byte = rd_valid_reg ? rdata : 8'd0;
    assign mask = COL_MSB >> col_reg;
    assign bit_val = ctrl.uw.led_src ? value_reg[LAST_ROW - ctrl.cnt] : led_on_reg;
    assign merged = bit_val ? (old_byte | mask) : (old_byte & ~mask);

    always_comb
    begin
        case (ctrl.uw.dat_sel)
            DAT_CONST: dat = ctrl.uw.dat_const;
            DAT_VALUE: dat = value_reg;
            DAT_POWER: dat = pwr_reg ? 8'd0 : RESUME_DATA;
            DAT_MERGE: dat = merged;
            default:   dat = ctrl.uw.dat_const;
        endcase
    end

    assign opc = ctrl.uw.opc_row ? ({1'b0, row_sel} + 4'd1) : ctrl.uw.opc_const;

    always_comb
    begin
        case (ctrl.uw.last_sel)
            LAST_NONE:   last_bit = 1'b0;
            LAST_ALWAYS: last_bit = 1'b1;
            LAST_CNT:    last_bit = ctrl.cnt == LAST_ROW;
            default:     last_bit = 1'b0;
        endcase
    end

    // frame register
    assign out_free = !out_valid_reg || !out_stall;
    assign load = ctrl.fire && ctrl.uw.emit;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dev_out_reg <= dev_reg;
            opc_out_reg <= opc;
            data_out_reg <= dat;
            last_out_reg <= last_bit;
        end
    end

    assign out_valid = out_valid_reg;
    assign device_res = dev_out_reg;
    assign opcode = opc_out_reg;
    assign data = data_out_reg;
    assign last = last_out_reg;

endmodule

### hdl/led_matrix_shadow_controller_top.sv
// Top level of the LED matrix shadow controller: APB register, sequencer and datapath.
// Depends on lmsc_pkg, lmsc_sequencer, lmsc_datapath (and lmsc_ram below it).
//
// Usage:
//  - Command channel (in_valid/in_stall): one transfer per command for a chain of
//    8x8 LED matrix drivers. in_stall is high while a command is being worked.
//  - Frame channel (out_valid/out_stall): one transfer per register-write frame
//    (device_res, opcode, data); last marks the final frame of a command.
//    Rejected commands (device not in use, intensity 16 or more, scan limit 8 or
//    more) produce no frame.
//  - Steps: a command is dispatched, then runs its microcode steps: one frame step
//    for set row, shutdown, intensity and scan limit; a read and a write for set
//    LED; eight row frames for clear; init adds four register frames; set column
//    a read and a write per row, set by the row loops and the single RAM port.
//  - First frame once the entry step fires (set LED and set column read first); set
//    column then alternates read and write steps, the rest emit every cycle unless stalled.
//  - A stalled frame holds in the output register; the sequencer freezes on its
//    next emitting step until the frame is taken. A new command can be taken
//    while the last frame still waits.
//  - Reset: all row shadows read as zero (per-entry valid bits, no clearing
//    pass), device_count returns to 8, no frame pending.
//  - Write device_count (APB offset 0) only while the block is idle; it does not enforce this.
module led_matrix_shadow_controller_top (
    input  logic                        clk,
    input  logic                        rst_n,
    // APB config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lmsc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // command channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [2:0]                  action,
    input  logic [2:0]                  device,
    input  logic [2:0]                  row,
    input  logic [2:0]                  column,
    input  logic [7:0]                  value,
    input  logic                        led_on,
    input  logic                        power_down,
    // frame channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [2:0]                  device_res,
    output logic [3:0]                  opcode,
    output logic [7:0]                  data,
    output logic                        last
);
    import lmsc_pkg::*;

    logic [3:0] device_count_reg;
    logic       reg_idx;
    logic       busy;
    logic       start;
    logic       out_free;
    ctrl_t      ctrl;

    // register index from the byte address, 4 bytes per register
    assign reg_idx = paddr[2];
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_count_reg <= DEVICE_COUNT_RESET;
        end
        else if (psel && penable && pwrite && reg_idx == REG_DEVICE_COUNT)
        begin
            device_count_reg <= pwdata[3:0];
        end
    end

    assign prdata = (reg_idx == REG_DEVICE_COUNT) ? {28'd0, device_count_reg} : 32'd0;

    // command transfer completes only when the sequencer sits idle
    assign in_stall = busy;
    assign start = in_valid && !busy;

    lmsc_sequencer u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .action      (action_t'(action)),
        .device      (device),
        .value       (value),
        .device_count(device_count_reg),
        .out_free    (out_free),
        .busy        (busy),
        .ctrl        (ctrl)
    );

    lmsc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .device    (device),
        .row       (row),
        .column    (column),
        .value     (value),
        .led_on    (led_on),
        .power_down(power_down),
        .ctrl      (ctrl),
        .out_free  (out_free),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .device_res(device_res),
        .opcode    (opcode),
        .data      (data),
        .last      (last)
    );

endmodule

### test/tb_led_matrix_shadow_controller_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_matrix_shadow_controller_top: directed table, then random phases.
// Depends on lmsc_pkg and the controller RTL; expected frames: in-bench row-shadow model or typed rows.
module tb_led_matrix_shadow_controller_top;
    import lmsc_pkg::*;

    // ------------------------------------------------------------------
    // Run parameters
    // ------------------------------------------------------------------
    localparam int ITEMS_PER_PHASE = 37;      // six random phases, ~220 commands
    localparam int SETTLE_CYCLES   = 24;      // outlasts the longest command
    localparam int HOLD_CYCLES     = 250;     // long receiver hold-off
    localparam longint RUN_LIMIT_NS = 10_000_000;

    // first row register; row r is written at OPC_ROW_BASE + r
    localparam logic [3:0] OPC_ROW_BASE = 4'd1;

    // ------------------------------------------------------------------
    // Types
    // ------------------------------------------------------------------
    typedef struct packed {
        action_t    act;
        logic [2:0] dev;
        logic [2:0] row;
        logic [2:0] col;
        logic [7:0] val;
        logic       on;
        logic       pd;
    } command_t;

    typedef struct packed {
        logic [2:0] dev;
        logic [3:0] opc;
        logic [7:0] dat;
        logic       lst;
    } frame_t;

    // how a directed row is checked: by the shadow model, no frame at all,
    // or one frame typed into the table
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_ONE
    } check_t;

    typedef enum logic {
        ROW_CMD,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [3:0] cfg;      // device_count for ROW_CFG
        check_t     chk;
        command_t   cmd;
        logic [3:0] t_opc;    // typed frame, CHK_ONE only
        logic [7:0] t_dat;
    } dir_row_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [2:0]           action = '0;
    logic [2:0]           device = '0;
    logic [2:0]           row = '0;
    logic [2:0]           column = '0;
    logic [7:0]           value = '0;
    logic                 led_on = 1'b0;
    logic                 power_down = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           device_res;
    logic [3:0]           opcode;
    logic [7:0]           data;
    logic                 last;

    led_matrix_shadow_controller_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .device     (device),
        .row        (row),
        .column     (column),
        .value      (value),
        .led_on     (led_on),
        .power_down (power_down),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .device_res (device_res),
        .opcode     (opcode),
        .data       (data),
        .last       (last)
    );

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Row-shadow model and expected frame store
    // ------------------------------------------------------------------
    logic [7:0] shadow_rows [0:MAX_DEVICES*8-1];
    logic [3:0] device_count_reg = DEVICE_COUNT_RESET;
    frame_t     cmd_frames[$];      // frames of the command just accepted
    frame_t     pending_frames[$];  // frames still owed by the DUT
    int         errors = 0;

    // traffic shaping shared between processes (written with NBAs)
    logic       no_gaps = 1'b0;
    logic       hold_go = 1'b0;
    logic       rx_hold = 1'b0;

    initial begin
        foreach (shadow_rows[i])
            shadow_rows[i] = 8'h00;
    end

    // zero or anything past the chain length means the whole chain
    function automatic int active_count();
        if (device_count_reg == 4'd0 || int'(device_count_reg) > MAX_DEVICES)
            return MAX_DEVICES;
        return int'(device_count_reg);
    endfunction

    function automatic void push_frame(logic [2:0] dev, logic [3:0] opc, logic [7:0] dat);
        frame_t f;
        f.dev = dev;
        f.opc = opc;
        f.dat = dat;
        f.lst = 1'b0;
        cmd_frames.push_back(f);
    endfunction

    // read-modify-write of one shadow row, then the row frame
    function automatic void update_led(logic [2:0] dev, logic [2:0] r, logic [7:0] mask,
                                       logic on);
        if (on)
            shadow_rows[{dev, r}] = shadow_rows[{dev, r}] | mask;
        else
            shadow_rows[{dev, r}] = shadow_rows[{dev, r}] & ~mask;
        push_frame(dev, OPC_ROW_BASE + {1'b0, r}, shadow_rows[{dev, r}]);
    endfunction

    function automatic void blank_rows(logic [2:0] dev);
        for (int r = 0; r < 8; r++) begin
            shadow_rows[{dev, 3'(r)}] = 8'h00;
            push_frame(dev, OPC_ROW_BASE + 4'(r), 8'h00);
        end
    endfunction

    // Works out the frames of one accepted command and updates the shadow.
    // keep=1 queues them as expected frames.
    function automatic void predict_frames(command_t c, bit keep);
        logic [7:0] mask;
        frame_t     f;
        cmd_frames.delete();
        mask = COL_MSB >> c.col;
        if (int'(c.dev) < active_count()) begin
            case (c.act)
                ACT_INIT: begin
                    push_frame(c.dev, OPC_TEST, 8'h00);
                    push_frame(c.dev, OPC_SCANLIMIT, SCAN_ALL);
                    push_frame(c.dev, OPC_DECODE, 8'h00);
                    blank_rows(c.dev);
                    push_frame(c.dev, OPC_SHUTDOWN, 8'h00);
                end
                ACT_LED:
                    update_led(c.dev, c.row, mask, c.on);
                ACT_ROW: begin
                    shadow_rows[{c.dev, c.row}] = c.val;
                    push_frame(c.dev, OPC_ROW_BASE + {1'b0, c.row}, c.val);
                end
                ACT_COLUMN:
                    // value msb lands on row 0
                    for (int r = 0; r < 8; r++)
                        update_led(c.dev, 3'(r), mask, c.val[7-r]);
                ACT_CLEAR:
                    blank_rows(c.dev);
                ACT_SHUT:
                    push_frame(c.dev, OPC_SHUTDOWN, c.pd ? 8'h00 : RESUME_DATA);
                ACT_INTENS:
                    if (c.val < INTENSITY_LIMIT)
                        push_frame(c.dev, OPC_INTENSITY, c.val);
                default:
                    if (c.val < SCAN_LIMIT)
                        push_frame(c.dev, OPC_SCANLIMIT, c.val);
            endcase
        end
        if (cmd_frames.size() > 0) begin
            f = cmd_frames.pop_back();
            f.lst = 1'b1;
            cmd_frames.push_back(f);
        end
        if (keep)
            foreach (cmd_frames[k])
                pending_frames.push_back(cmd_frames[k]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps || p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly commands to devices in use, with accepted intensity and scan
    // values; the rest hit unused devices and out-of-range values.
    function automatic command_t random_command();
        command_t c;
        c.act = action_t'($urandom_range(0, 7));
        if ($urandom_range(0, 99) < 85)
            c.dev = 3'($urandom_range(0, active_count() - 1));
        else
            c.dev = 3'($urandom_range(0, 7));
        c.row = 3'($urandom_range(0, 7));
        c.col = 3'($urandom_range(0, 7));
        c.val = 8'($urandom_range(0, 255));
        if (c.act == ACT_INTENS && $urandom_range(0, 9) < 7)
            c.val = 8'($urandom_range(0, 15));
        if (c.act == ACT_SCAN && $urandom_range(0, 9) < 7)
            c.val = 8'($urandom_range(0, 7));
        c.on = 1'($urandom_range(0, 1));
        c.pd = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happened.
    // in_valid is left high so a back-to-back command needs no re-raise.
    task automatic drive_command(command_t c, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action     <= c.act;
        device     <= c.dev;
        row        <= c.row;
        column     <= c.col;
        value      <= c.val;
        led_on     <= c.on;
        power_down <= c.pd;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drain: every frame back, then room for a command that emits nothing.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (pending_frames.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access; pready is tied high but honored.
    // Upper data bits are random, only the low nibble counts.
    task automatic write_device_count(logic [3:0] cnt);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(REG_DEVICE_COUNT));
        pwdata  <= ($urandom() & 32'hFFFF_FFF0) | 32'(cnt);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        device_count_reg = cnt;
    endtask

    // ------------------------------------------------------------------
    // Directed table. Typed frames only where the answer is obvious;
    // the typed frame always goes to the command's device with last set.
    // ------------------------------------------------------------------
    dir_row_t dir_table [$] = '{
        // reset shadow and count: corner rows and corner columns
        '{ROW_CMD, 4'd0, CHK_ONE, '{ACT_ROW, 3'd0, 3'd0, 3'd0, 8'hFF, 1'b0, 1'b0},
          OPC_ROW_BASE, 8'hFF},
        '{ROW_CMD, 4'd0, CHK_ONE, '{ACT_ROW, 3'd7, 3'd7, 3'd7, 8'h00, 1'b1, 1'b1},
          OPC_ROW_BASE + 4'd7, 8'h00},
        '{ROW_CMD, 4'd0, CHK_ONE, '{ACT_LED, 3'd0, 3'd0, 3'd7, 8'h00, 1'b0, 1'b0},
          OPC_ROW_BASE, 8'hFE},
        '{ROW_CMD, 4'd0, CHK_ONE, '{ACT_LED, 3'd7, 3'd7, 3'd0, 8'hFF, 1'b1, 1'b0},
          OPC_ROW_BASE + 4'd7, 8'h80},
        // set column merges into existing rows, eight frames
        '{ROW_CMD, 4'd0, CHK_MODEL, '{ACT_COLUMN, 3'd0, 3'd0, 3'd0, 8'hA5, 1'b0, 1'b0},
          4'd0, 8'h00},
        '{ROW_CMD, 4'd0, CHK_MODEL, '{ACT_COLUMN, 3'd7, 3'd5, 3'd7, 8'hFF, 1'b1, 1'b1},
          4'd0, 8'h00},
        '{ROW_CMD, 4'd0, CHK_MODEL, '{ACT_INIT, 3'd3, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0},
          4'd0, 8'h00},
        '{ROW_CMD, 4'd0, CHK_MODEL, '{ACT_CLEAR, 3'd0, 3'd2, 3'd4, 8'h3C, 1'b0, 1'b0},
          4'd0, 8'h00},
        // shutdown both ways
        '{ROW_CMD, 4'd0, CHK_ONE, '{ACT_SHUT, 3'd1, 3'd0, 3'd0, 8'h00, 1'b0, 1'b1},
          OPC_SHUTDOWN, 8'h00},
        '{ROW_CMD, 4'd0, CHK_ONE, '{ACT_SHUT, 3'd1, 3'd0, 3'd0, 8'hFF, 1'b1, 1'b0},
          OPC_SHUTDOWN, RESUME_DATA},
        // intensity limits, then too large
        '{ROW_CMD, 4'd0, CHK_ONE, '{ACT_INTENS, 3'd2, 3'd0, 3'd0, 8'd0, 1'b0, 1'b0},
          OPC_INTENSITY, 8'd0},
        '{ROW_CMD, 4'd0, CHK_ONE, '{ACT_INTENS, 3'd2, 3'd0, 3'd0, 8'd15, 1'b0, 1'b0},
          OPC_INTENSITY, 8'd15},
        '{ROW_CMD, 4'd0, CHK_NONE, '{ACT_INTENS, 3'd2, 3'd0, 3'd0, 8'd16, 1'b0, 1'b0},
          4'd0, 8'h00},
        '{ROW_CMD, 4'd0, CHK_NONE, '{ACT_INTENS, 3'd2, 3'd0, 3'd0, 8'd255, 1'b0, 1'b0},
          4'd0, 8'h00},
        // scan limit limits, then too large
        '{ROW_CMD, 4'd0, CHK_ONE, '{ACT_SCAN, 3'd4, 3'd0, 3'd0, 8'd0, 1'b0, 1'b0},
          OPC_SCANLIMIT, 8'd0},
        '{ROW_CMD, 4'd0, CHK_ONE, '{ACT_SCAN, 3'd4, 3'd0, 3'd0, 8'd7, 1'b0, 1'b0},
          OPC_SCANLIMIT, 8'd7},
        '{ROW_CMD, 4'd0, CHK_NONE, '{ACT_SCAN, 3'd4, 3'd0, 3'd0, 8'd8, 1'b0, 1'b0},
          4'd0, 8'h00},
        '{ROW_CMD, 4'd0, CHK_NONE, '{ACT_SCAN, 3'd4, 3'd0, 3'd0, 8'd255, 1'b0, 1'b0},
          4'd0, 8'h00},
        '{ROW_CMD, 4'd0, CHK_MODEL, '{ACT_COLUMN, 3'd5, 3'd0, 3'd3, 8'h00, 1'b0, 1'b0},
          4'd0, 8'h00},
        '{ROW_CMD, 4'd0, CHK_MODEL, '{ACT_LED, 3'd5, 3'd3, 3'd3, 8'h00, 1'b1, 1'b0},
          4'd0, 8'h00},
        '{ROW_CMD, 4'd0, CHK_MODEL, '{ACT_INIT, 3'd7, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0},
          4'd0, 8'h00},
        // single device: everything past device 0 is dropped
        '{ROW_CFG, 4'd1, CHK_NONE, '{ACT_INIT, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0},
          4'd0, 8'h00},
        '{ROW_CMD, 4'd0, CHK_NONE, '{ACT_ROW, 3'd1, 3'd0, 3'd0, 8'h55, 1'b0, 1'b0},
          4'd0, 8'h00},
        '{ROW_CMD, 4'd0, CHK_ONE, '{ACT_ROW, 3'd0, 3'd2, 3'd0, 8'h3C, 1'b0, 1'b0},
          OPC_ROW_BASE + 4'd2, 8'h3C},
        // zero count means the full chain again
        '{ROW_CFG, 4'd0, CHK_NONE, '{ACT_INIT, 3'd0, 3'd0, 3'd0, 8'h00, 1'b0, 1'b0},
          4'd0, 8'h00},
        '{ROW_CMD, 4'd0, CHK_ONE, '{ACT_INTENS, 3'd7, 3'd0, 3'd0, 8'd8, 1'b0, 1'b0},
          OPC_INTENSITY, 8'd8}
    };

    // device_count per random phase: extremes, out-of-range and in between
    logic [3:0] count_plan [6] = '{4'd1, 4'd15, 4'd3, 4'd8, 4'd0, 4'd5};

    // ------------------------------------------------------------------
    // Sender: reset, directed table, random phases, end of run
    // ------------------------------------------------------------------
    initial begin
        command_t cmd;
        frame_t   typed;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG) begin
                wait_until_idle();
                write_device_count(dir_table[i].cfg);
            end else begin
                cmd = dir_table[i].cmd;
                drive_command(cmd, pick_gap());
                // the model still runs on typed rows to keep the shadow current
                predict_frames(cmd, dir_table[i].chk == CHK_MODEL);
                if (dir_table[i].chk == CHK_ONE) begin
                    typed.dev = cmd.dev;
                    typed.opc = dir_table[i].t_opc;
                    typed.dat = dir_table[i].t_dat;
                    typed.lst = 1'b1;
                    pending_frames.push_back(typed);
                end
            end
        end

        // phase 1 runs with no idling on either side; phase 3 carries the
        // long receiver hold-off
        foreach (count_plan[p]) begin
            wait_until_idle();
            write_device_count(count_plan[p]);
            no_gaps <= (p == 1);
            hold_go <= (p == 3);
            repeat (ITEMS_PER_PHASE) begin
                cmd = random_command();
                drive_command(cmd, pick_gap());
                predict_frames(cmd, 1'b1);
            end
        end

        wait_until_idle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, mostly short, a few long
    // ------------------------------------------------------------------
    int   rx_left = 0;
    logic rx_busy = 1'b0;

    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_busy = ($urandom_range(0, 99) < 35);
            if (!rx_busy)
                rx_left = $urandom_range(1, 20);
            else if ($urandom_range(0, 9) < 8)
                rx_left = $urandom_range(1, 3);
            else
                rx_left = $urandom_range(15, 60);
        end
        rx_left--;
        out_stall <= rx_hold || (rx_busy && !no_gaps);
    end

    // Long hold-off, counted here; the sender keeps offering commands so
    // the block backs up and stalls its command input.
    initial begin
        do
            @(posedge clk);
        while (!hold_go);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Frame checker: each transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        frame_t got;
        frame_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{device_res, opcode, data, last};
            if (pending_frames.size() == 0) begin
                errors++;
                $display("%0t: unexpected frame dev=%0d opc=%0d data=%02h last=%0b",
                         $time, got.dev, got.opc, got.dat, got.lst);
            end else begin
                want = pending_frames.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t: frame mismatch expected dev=%0d opc=%0d data=%02h last=%0b",
                             $time, want.dev, want.opc, want.dat, want.lst);
                    $display("%0t:                  actual dev=%0d opc=%0d data=%02h last=%0b",
                             $time, got.dev, got.opc, got.dat, got.lst);
                end
            end
        end
    end

    // hard stop: frames missing or a handshake that never completes
    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### files.f
hdl/lmsc_pkg.sv
hdl/lmsc_ram.sv
hdl/lmsc_sequencer.sv
hdl/lmsc_datapath.sv
hdl/led_matrix_shadow_controller_top.sv
test/tb_led_matrix_shadow_controller_top.sv
